// ----- design/bubble_sort_engine_defines.svh -----
// assertion macros shared by the bubble sort engine rtl
// depends on: nothing; included by modules that carry assertions
`ifndef BUBBLE_SORT_ENGINE_DEFINES_SVH
`define BUBBLE_SORT_ENGINE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BSE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bubble sort engine: same-cycle check failed");

// next-cycle implication, checked outside reset
`define BSE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bubble sort engine: next-cycle check failed");

`endif

// ----- design/bse_pkg.sv -----
// shared types and constants of the bubble sort engine
// depends on: nothing
package bse_pkg;

   localparam int DATA_W        = 32;
   localparam int DEPTH_DEFAULT = 16;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     last_in;
   } req_payload_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] sorted_value;
      logic                     last_out;
      logic                     dropped;
   } rsp_payload_type;

   // outcome of one compare-and-swap step
   typedef struct packed {
      logic                     swap;
      logic signed [DATA_W-1:0] low_word;
      logic signed [DATA_W-1:0] carry_word;
   } cs_result_type;

endpackage

// ----- design/bse_store.sv -----
// element buffer: one write port, one read port with registered read data
// depends on: bse_pkg
module bse_store #(
   parameter int DEPTH = bse_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [$clog2(DEPTH)-1:0]          wr_addr,
   input  logic signed [bse_pkg::DATA_W-1:0] wr_data,
   input  logic                              rd_en,
   input  logic [$clog2(DEPTH)-1:0]          rd_addr,
   output logic signed [bse_pkg::DATA_W-1:0] rd_data
);

   logic signed [bse_pkg::DATA_W-1:0] mem_ff [DEPTH];
   logic signed [bse_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/bse_cmp_swap.sv -----
// shared compare-and-swap unit: carried element against the next stored one
// depends on: bse_pkg
module bse_cmp_swap (
   input  logic signed [bse_pkg::DATA_W-1:0] carry_word,
   input  logic signed [bse_pkg::DATA_W-1:0] next_word,
   input  logic                              descending,
   output bse_pkg::cs_result_type            result
);

   logic out_of_order;

   assign out_of_order = descending ? (carry_word < next_word) : (carry_word > next_word);

   // on a swap the carried element moves on, otherwise the next one is carried
   always_comb begin
      result.swap       = out_of_order;
      result.low_word   = out_of_order ? next_word : carry_word;
      result.carry_word = out_of_order ? carry_word : next_word;
   end

endmodule

// ----- design/bubble_sort_engine.sv -----
// bubble sort engine: load stores beats while req_ready is high; sorts in at most count
// passes, one compare-and-swap per cycle in S_STEP; emission reads, then offers each result beat.
// one set at a time: req_ready is low from the last-marked beat until the final result.
// synchronous active-high reset clears fill count, overflow flag, order (ascending) and
// sequencer; buffer contents are undefined until written.
// depends on: bse_pkg, bse_store, bse_cmp_swap, bubble_sort_engine_defines.svh
`include "bubble_sort_engine_defines.svh"

module bubble_sort_engine #(
   parameter int DEPTH = bse_pkg::DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  bse_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output bse_pkg::rsp_payload_type rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic                     csr_data
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam logic [2:0] S_LOAD     = 3'd0;
   localparam logic [2:0] S_PRIME    = 3'd1;
   localparam logic [2:0] S_CARRY    = 3'd2;
   localparam logic [2:0] S_STEP     = 3'd3;
   localparam logic [2:0] S_TAIL     = 3'd4;
   localparam logic [2:0] S_OUT_RD   = 3'd5;
   localparam logic [2:0] S_OUT_WAIT = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic             ovf_ff, ovf_in;
   logic             drop_ff, drop_in;
   logic             swapped_ff, swapped_in;
   logic             desc_ff;
   logic signed [bse_pkg::DATA_W-1:0] carry_ff, carry_in;

   logic                              wr_en;
   logic [IDX_W-1:0]                  wr_addr;
   logic signed [bse_pkg::DATA_W-1:0] wr_data;
   logic                              rd_en;
   logic [IDX_W-1:0]                  rd_addr;
   logic signed [bse_pkg::DATA_W-1:0] rd_data;
   bse_pkg::cs_result_type            cs;

   logic             full;
   logic             last_pair;
   logic             out_last;
   logic [IDX_W-1:0] tail_addr;

   bse_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bse_cmp_swap u_cmp_swap (
      .carry_word (carry_ff),
      .next_word  (rd_data),
      .descending (desc_ff),
      .result     (cs)
   );

   assign full      = (fill_ff == CNT_W'(DEPTH));
   assign last_pair = ((CNT_W'(k_ff) + CNT_W'(2)) == cnt_ff);
   assign out_last  = ((CNT_W'(k_ff) + CNT_W'(1)) == cnt_ff);
   assign tail_addr = IDX_W'(cnt_ff - CNT_W'(1));

   assign req_ready = (state_ff == S_LOAD);
   assign csr_ready = 1'b1;
   assign rsp_valid = (state_ff == S_OUT_WAIT);

   always_comb begin
      rsp_data.sorted_value = rd_data;
      rsp_data.last_out     = out_last;
      rsp_data.dropped      = drop_ff;
   end

   always_comb begin
      state_in   = state_ff;
      fill_in    = fill_ff;
      cnt_in     = cnt_ff;
      k_in       = k_ff;
      ovf_in     = ovf_ff;
      drop_in    = drop_ff;
      swapped_in = swapped_ff;
      carry_in   = carry_ff;
      wr_en      = 1'b0;
      wr_addr    = '0;
      wr_data    = '0;
      rd_en      = 1'b0;
      rd_addr    = '0;
      case (state_ff)
         S_LOAD: begin
            if (req_valid) begin
               if (!full) begin
                  wr_en   = 1'b1;
                  wr_addr = IDX_W'(fill_ff);
                  wr_data = req_data.value;
                  fill_in = fill_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_data.last_in) begin
                  cnt_in  = full ? CNT_W'(DEPTH) : (fill_ff + CNT_W'(1));
                  drop_in = ovf_ff | full;
                  k_in    = '0;
                  // a single element needs no pass
                  state_in = (full || fill_ff != '0) ? S_PRIME : S_OUT_RD;
               end
            end
         end
         S_PRIME: begin
            rd_en      = 1'b1;
            rd_addr    = '0;
            k_in       = '0;
            swapped_in = 1'b0;
            state_in   = S_CARRY;
         end
         S_CARRY: begin
            carry_in = rd_data;
            rd_en    = 1'b1;
            rd_addr  = k_ff + IDX_W'(1);
            state_in = S_STEP;
         end
         S_STEP: begin
            wr_en    = 1'b1;
            wr_addr  = k_ff;
            wr_data  = cs.low_word;
            carry_in = cs.carry_word;
            if (cs.swap) begin
               swapped_in = 1'b1;
            end
            if (last_pair) begin
               state_in = S_TAIL;
            end else begin
               rd_en   = 1'b1;
               rd_addr = k_ff + IDX_W'(2);
               k_in    = k_ff + IDX_W'(1);
            end
         end
         S_TAIL: begin
            // carried element lands in the last slot of this pass
            wr_en    = 1'b1;
            wr_addr  = tail_addr;
            wr_data  = carry_ff;
            k_in     = '0;
            state_in = swapped_ff ? S_PRIME : S_OUT_RD;
         end
         S_OUT_RD: begin
            rd_en    = 1'b1;
            rd_addr  = k_ff;
            state_in = S_OUT_WAIT;
         end
         S_OUT_WAIT: begin
            if (rsp_ready) begin
               if (out_last) begin
                  fill_in  = '0;
                  ovf_in   = 1'b0;
                  k_in     = '0;
                  state_in = S_LOAD;
               end else begin
                  k_in     = k_ff + IDX_W'(1);
                  state_in = S_OUT_RD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_LOAD;
         fill_ff    <= '0;
         cnt_ff     <= '0;
         k_ff       <= '0;
         ovf_ff     <= 1'b0;
         drop_ff    <= 1'b0;
         swapped_ff <= 1'b0;
         desc_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         cnt_ff     <= cnt_in;
         k_ff       <= k_in;
         ovf_ff     <= ovf_in;
         drop_ff    <= drop_in;
         swapped_ff <= swapped_in;
         if (csr_valid && csr_ready) begin
            desc_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      carry_ff <= carry_in;
   end

   `BSE_ASSERT_IMPL(a_fill_bound, clock, reset, 1'b1, fill_ff <= CNT_W'(DEPTH))
   `BSE_ASSERT_IMPL(a_no_load_while_emit, clock, reset, rsp_valid, !req_ready)
   `BSE_ASSERT_IMPL(a_step_in_range, clock, reset, state_ff == S_STEP,
      (CNT_W'(k_ff) + CNT_W'(2)) <= cnt_ff)
   `BSE_ASSERT_NEXT(a_final_beat_empties, clock, reset,
      rsp_valid && rsp_ready && rsp_data.last_out,
      (state_ff == S_LOAD) && (fill_ff == '0) && !ovf_ff)

endmodule

// ----- sim/bubble_sort_engine_test.sv -----
// self-checking testbench of the bubble sort engine: directed and random sets,
// a bench-side sort predictor and random valid/ready idling on the request and result channels
// depends on: bse_pkg, bubble_sort_engine
`timescale 1ns / 100ps

module bubble_sort_engine_test;

   localparam int   SET_DEPTH        = bse_pkg::DEPTH_DEFAULT;
   localparam int   STALL_LIMIT      = 5000;
   localparam int   DRAIN_WAIT       = 400;
   localparam int   SETTLE_WAIT      = 40;
   localparam int   PRINT_LIMIT      = 100;
   localparam int   PHASE_BEATS      = 76;
   localparam logic ORDER_ASCENDING  = 1'b0;
   localparam logic ORDER_DESCENDING = 1'b1;
   localparam logic signed [bse_pkg::DATA_W-1:0] VALUE_MAX =
      {1'b0, {(bse_pkg::DATA_W-1){1'b1}}};
   localparam logic signed [bse_pkg::DATA_W-1:0] VALUE_MIN =
      {1'b1, {(bse_pkg::DATA_W-1){1'b0}}};

   logic                     clock     = 1'b0;
   logic                     reset     = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   bse_pkg::req_payload_type req_data  = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   bse_pkg::rsp_payload_type rsp_data;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic                     csr_data  = 1'b0;

   bse_pkg::req_payload_type pending_beats[$];
   bse_pkg::rsp_payload_type sorted_beats_due[$];
   logic                     pending_orders[$];

   int send_idle_pct = 12;
   int recv_idle_pct = 71;
   int error_count   = 0;
   int idle_cycles   = 0;

   // sort predictor state
   logic signed [bse_pkg::DATA_W-1:0] held_values [SET_DEPTH];
   int                                fill_level       = 0;
   logic                              overflow_flag    = 1'b0;
   logic                              order_descending = ORDER_ASCENDING;
   logic signed [bse_pkg::DATA_W-1:0] swap_word;
   logic                              swapped;
   int                                slot;
   bse_pkg::rsp_payload_type          due_beat;

   bubble_sort_engine #(.DEPTH(SET_DEPTH)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic report_mismatch(string what);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("[%0t] mismatch: %s", $time, what);
   endtask

   function automatic logic signed [bse_pkg::DATA_W-1:0] pick_value();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 25) begin
         pick_value = $urandom_range(8) - 4;  // narrow range, lots of ties
      end else if (sel < 40) begin
         case ($urandom_range(3))
            0: pick_value = VALUE_MAX;
            1: pick_value = VALUE_MIN;
            2: pick_value = '0;
            default: pick_value = '1;
         endcase
      end else begin
         pick_value = $urandom;
      end
   endfunction

   function automatic int pick_size();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 70)
         pick_size = $urandom_range(8, 1);
      else if (sel < 90)
         pick_size = $urandom_range(SET_DEPTH, 9);
      else
         pick_size = $urandom_range(SET_DEPTH + 4, SET_DEPTH + 1);  // overflowing sets
   endfunction

   function automatic void push_beat(logic signed [bse_pkg::DATA_W-1:0] v, logic last);
      bse_pkg::req_payload_type beat;
      beat.value   = v;
      beat.last_in = last;
      pending_beats.push_back(beat);
   endfunction

   task automatic wait_idle();
      do begin
         @(negedge clock);
      end while (pending_beats.size() != 0 || req_valid || sorted_beats_due.size() != 0 ||
                 pending_orders.size() != 0 || csr_valid);
   endtask

   task automatic write_order(logic order);
      wait_idle();
      repeat (SETTLE_WAIT) @(negedge clock);
      pending_orders.push_back(order);
      wait_idle();
   endtask

   task automatic run_sets(int target);
      int pushed;
      int size;
      pushed = 0;
      while (pushed < target) begin
         size = pick_size();
         for (int i = 0; i < size; i++)
            push_beat(pick_value(), i == size - 1);
         pushed += size;
         // now and then hold the sender until the engine has drained
         if ($urandom_range(9) == 0)
            wait_idle();
      end
      wait_idle();
   endtask

   // stimulus driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data  <= pending_beats.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // register writes; the predictor follows the order on each accepted beat
   always @(posedge clock) begin
      if (reset) begin
         csr_valid <= 1'b0;
      end else begin
         if (csr_valid && csr_ready)
            order_descending = csr_data;
         if (!csr_valid || csr_ready) begin
            if (pending_orders.size() != 0) begin
               csr_data  <= pending_orders.pop_front();
               csr_valid <= 1'b1;
            end else begin
               csr_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= $urandom_range(99) >= recv_idle_pct;
   end

   // monitor: predict sorted sets on input beats, check result beats
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (sorted_beats_due.size() == 0) begin
               report_mismatch($sformatf("result %0d with nothing due", rsp_data.sorted_value));
            end else begin
               due_beat = sorted_beats_due.pop_front();
               if (rsp_data.sorted_value !== due_beat.sorted_value)
                  report_mismatch($sformatf("sorted_value %0d, due %0d",
                                            rsp_data.sorted_value, due_beat.sorted_value));
               if (rsp_data.last_out !== due_beat.last_out)
                  report_mismatch($sformatf("last_out %b, due %b",
                                            rsp_data.last_out, due_beat.last_out));
               if (rsp_data.dropped !== due_beat.dropped)
                  report_mismatch($sformatf("dropped %b, due %b",
                                            rsp_data.dropped, due_beat.dropped));
            end
         end

         if (req_valid && req_ready) begin
            if (fill_level < SET_DEPTH) begin
               held_values[fill_level] = req_data.value;
               fill_level++;
            end else begin
               overflow_flag = 1'b1;
            end
            if (req_data.last_in) begin
               swapped = 1'b1;
               while (swapped && fill_level > 1) begin
                  swapped = 1'b0;
                  for (slot = 0; slot + 1 < fill_level; slot++) begin
                     if (order_descending ? (held_values[slot] < held_values[slot + 1])
                                          : (held_values[slot] > held_values[slot + 1])) begin
                        swap_word               = held_values[slot];
                        held_values[slot]       = held_values[slot + 1];
                        held_values[slot + 1]   = swap_word;
                        swapped                 = 1'b1;
                     end
                  end
               end
               for (slot = 0; slot < fill_level; slot++) begin
                  due_beat.sorted_value = held_values[slot];
                  due_beat.last_out     = (slot == fill_level - 1);
                  due_beat.dropped      = overflow_flag;
                  sorted_beats_due.push_back(due_beat);
               end
               fill_level    = 0;
               overflow_flag = 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // sender idles rarely, receiver often
      send_idle_pct = 12;
      recv_idle_pct = 71;
      write_order(ORDER_ASCENDING);
      push_beat(VALUE_MAX, 1'b1);
      // extremes with a tie
      push_beat(VALUE_MAX, 1'b0);
      push_beat(VALUE_MIN, 1'b0);
      push_beat(0, 1'b0);
      push_beat(-1, 1'b0);
      push_beat(VALUE_MAX, 1'b1);
      // full buffer: the last-marked beat is dropped but still starts the sort
      for (int i = 0; i < SET_DEPTH; i++)
         push_beat(pick_value(), 1'b0);
      push_beat(pick_value(), 1'b1);
      wait_idle();
      write_order(ORDER_DESCENDING);
      run_sets(PHASE_BEATS);

      send_idle_pct = 71;
      recv_idle_pct = 12;
      write_order(ORDER_ASCENDING);
      run_sets(PHASE_BEATS);
      write_order(ORDER_DESCENDING);
      run_sets(PHASE_BEATS);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_order(ORDER_ASCENDING);
      run_sets(PHASE_BEATS);
      write_order($urandom_range(1) ? ORDER_DESCENDING : ORDER_ASCENDING);
      run_sets(PHASE_BEATS);

      wait_idle();
      repeat (DRAIN_WAIT) @(negedge clock);
      if (error_count == 0 && sorted_beats_due.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
